// ----- rtl/core/method_descriptor_slot_counter_unit_assert.svh -----
// assertion macros shared by the descriptor slot counter modules
// expects signals named clk and rst in the module that uses them
`ifndef METHOD_DESCRIPTOR_SLOT_COUNTER_UNIT_ASSERT_SVH
`define METHOD_DESCRIPTOR_SLOT_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MDSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mdsc assertion failed");

// next-cycle implication, checked out of reset
`define MDSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdsc assertion failed");

`endif

// ----- rtl/core/mdsc_pkg.sv -----
// types, codes and character constants for the method descriptor slot counter
// no dependencies
package mdsc_pkg;

  localparam int CharW  = 8;
  localparam int SlotW  = 9;
  localparam int OutW   = 8;
  localparam int StatW  = 2;

  localparam logic [CharW-1:0] CH_OPEN  = 8'h28; // (
  localparam logic [CharW-1:0] CH_CLOSE = 8'h29; // )
  localparam logic [CharW-1:0] CH_V     = 8'h56;
  localparam logic [CharW-1:0] CH_L     = 8'h4C;
  localparam logic [CharW-1:0] CH_ARRAY = 8'h5B; // [
  localparam logic [CharW-1:0] CH_J     = 8'h4A;
  localparam logic [CharW-1:0] CH_D     = 8'h44;
  localparam logic [CharW-1:0] CH_SEMI  = 8'h3B; // ;
  localparam logic [CharW-1:0] CH_B     = 8'h42;
  localparam logic [CharW-1:0] CH_C     = 8'h43;
  localparam logic [CharW-1:0] CH_F     = 8'h46;
  localparam logic [CharW-1:0] CH_I     = 8'h49;
  localparam logic [CharW-1:0] CH_S     = 8'h53;
  localparam logic [CharW-1:0] CH_Z     = 8'h5A;

  localparam logic [SlotW-1:0] SLOT_CAP = {SlotW{1'b1}};
  localparam logic [OutW-1:0]  OUT_MAX  = {OutW{1'b1}};

  typedef enum logic [2:0] {
    PH_OPEN   = 3'd0,
    PH_PARAMS = 3'd1,
    PH_PCLASS = 3'd2,
    PH_RET    = 3'd3,
    PH_RCLASS = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             is_last;
    logic             is_static;
  } byte_t;

  typedef struct packed {
    status_t         status;
    logic [OutW-1:0] arg_slots;
  } result_t;

  function automatic logic is_base(input logic [CharW-1:0] c);
    return (c == CH_B) || (c == CH_C) || (c == CH_D) || (c == CH_F) ||
           (c == CH_I) || (c == CH_J) || (c == CH_S) || (c == CH_Z);
  endfunction

endpackage

// ----- rtl/core/mdsc_in_reg.sv -----
// input register for descriptor bytes
// depends on mdsc_pkg
module mdsc_in_reg import mdsc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  byte_t din,
  input  logic  drain,
  output logic  held,
  output byte_t dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (drain) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

// ----- rtl/core/mdsc_parse.sv -----
// descriptor parser: phase register, slot counter and result logic
// depends on mdsc_pkg and the assertion macro header
module mdsc_parse import mdsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  byte_t   din,
  output result_t res
);

`include "method_descriptor_slot_counter_unit_assert.svh"

  phase_t           parse_phase, parse_phase_next;
  logic             array_pending, array_pending_next;
  logic [SlotW-1:0] slot_total, slot_total_next;
  logic             syntax_bad, syntax_bad_next;

  phase_t           ph_upd;
  logic             ap_upd;
  logic             bad_upd;
  logic [1:0]       add_n;
  logic [SlotW:0]   slot_sum;
  logic [SlotW-1:0] slot_upd;
  logic             bad_final;
  logic [SlotW:0]   total;

  always_comb begin
    ph_upd  = parse_phase;
    ap_upd  = array_pending;
    bad_upd = syntax_bad;
    add_n   = 2'd0;
    if (!syntax_bad) begin
      unique case (parse_phase)
        PH_OPEN: begin
          if (din.char_code == CH_OPEN) ph_upd = PH_PARAMS;
          else bad_upd = 1'b1;
        end
        PH_PARAMS: begin
          priority if (din.char_code == CH_ARRAY) begin
            ap_upd = 1'b1;
          end else if (is_base(din.char_code)) begin
            // a bare long or double takes two slots
            add_n  = (!array_pending &&
                      (din.char_code == CH_J || din.char_code == CH_D)) ? 2'd2 : 2'd1;
            ap_upd = 1'b0;
          end else if (din.char_code == CH_L) begin
            ph_upd = PH_PCLASS;
          end else if (din.char_code == CH_CLOSE && !array_pending) begin
            ph_upd = PH_RET;
          end else begin
            bad_upd = 1'b1;
          end
        end
        PH_PCLASS: begin
          if (din.char_code == CH_SEMI) begin
            add_n  = 2'd1;
            ap_upd = 1'b0;
            ph_upd = PH_PARAMS;
          end
        end
        PH_RET: begin
          priority if (din.char_code == CH_ARRAY) begin
            ap_upd = 1'b1;
          end else if (is_base(din.char_code) ||
                       (din.char_code == CH_V && !array_pending)) begin
            ap_upd = 1'b0;
            ph_upd = PH_DONE;
          end else if (din.char_code == CH_L) begin
            ph_upd = PH_RCLASS;
          end else begin
            bad_upd = 1'b1;
          end
        end
        PH_RCLASS: begin
          if (din.char_code == CH_SEMI) begin
            ap_upd = 1'b0;
            ph_upd = PH_DONE;
          end
        end
        default: bad_upd = 1'b1; // trailing bytes after the return type
      endcase
    end

    slot_sum = {1'b0, slot_total} + {{(SlotW-1){1'b0}}, add_n};
    slot_upd = slot_sum[SlotW] ? SLOT_CAP : slot_sum[SlotW-1:0];

    // unfinished descriptor on the last byte
    bad_final = bad_upd || (ph_upd != PH_DONE);
    total     = {1'b0, slot_upd} + {{SlotW{1'b0}}, !din.is_static};

    priority if (bad_final) begin
      res.status    = ST_SYNTAX;
      res.arg_slots = '0;
    end else if (total > {{(SlotW+1-OutW){1'b0}}, OUT_MAX}) begin
      res.status    = ST_OVERFLOW;
      res.arg_slots = OUT_MAX;
    end else begin
      res.status    = ST_OK;
      res.arg_slots = total[OutW-1:0];
    end

    parse_phase_next   = parse_phase;
    array_pending_next = array_pending;
    slot_total_next    = slot_total;
    syntax_bad_next    = syntax_bad;
    if (take) begin
      if (din.is_last) begin
        parse_phase_next   = PH_OPEN;
        array_pending_next = 1'b0;
        slot_total_next    = '0;
        syntax_bad_next    = 1'b0;
      end else begin
        parse_phase_next   = ph_upd;
        array_pending_next = ap_upd;
        slot_total_next    = slot_upd;
        syntax_bad_next    = bad_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_OPEN;
      array_pending <= 1'b0;
      slot_total    <= '0;
      syntax_bad    <= 1'b0;
    end else begin
      parse_phase   <= parse_phase_next;
      array_pending <= array_pending_next;
      slot_total    <= slot_total_next;
      syntax_bad    <= syntax_bad_next;
    end
  end

  `MDSC_ASSERT_NEXT(a_clear_after_last, take && din.is_last,
    parse_phase == PH_OPEN && slot_total == '0 && !syntax_bad && !array_pending)
  `MDSC_ASSERT_NEXT(a_count_monotonic, !(take && din.is_last),
    slot_total >= $past(slot_total))
  `MDSC_ASSERT_IMPL(a_pending_phase, array_pending,
    parse_phase != PH_OPEN && parse_phase != PH_DONE)

endmodule

// ----- rtl/core/mdsc_out_reg.sv -----
// result register holding one finished result until it is taken
// depends on mdsc_pkg
module mdsc_out_reg import mdsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  input  logic    stall,
  output logic    valid,
  output result_t dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

// ----- rtl/core/method_descriptor_slot_counter_unit.sv -----
// top level of the method descriptor argument slot counter
// depends on mdsc_pkg, mdsc_in_reg, mdsc_parse, mdsc_out_reg and the assertion header
//
// Takes a method descriptor one byte per item, checks its syntax and counts the
// argument slots a call needs (long and double take two, every other parameter
// one, plus one receiver slot unless is_static is set on the last byte). Only the
// item marked is_last gives a result: status 0 with the count, 1 for a syntax
// error (arg_slots 0), or 2 when the count passes 255 (arg_slots 255). The block
// takes one byte per clock while item_stall is low. An item goes into an input
// register, from which the parser takes it; a result is loaded into the result
// register when its last byte leaves the input register. Bytes that are not
// last always move on; a last byte waits in the input register only while the
// result register is full and stalled, and only then is item_stall raised.
module method_descriptor_slot_counter_unit import mdsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // byte channel
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [CharW-1:0] char_code,
  input  logic             is_last,
  input  logic             is_static,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output logic [StatW-1:0] status,
  output logic [OutW-1:0]  arg_slots
);

`include "method_descriptor_slot_counter_unit_assert.svh"

  byte_t   in_byte;
  byte_t   held_byte;
  logic    held;
  logic    take;
  logic    accept;
  logic    res_load;
  result_t res_comb;
  result_t res_held;

  assign in_byte.char_code = char_code;
  assign in_byte.is_last   = is_last;
  assign in_byte.is_static = is_static;

  // a held byte moves on unless it needs the result slot and that slot is blocked
  assign take       = held && (!held_byte.is_last || !result_valid || !result_stall);
  assign item_stall = held && !take;
  assign accept     = item_valid && !item_stall;
  assign res_load   = take && held_byte.is_last;

  mdsc_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .din   (in_byte),
    .drain (take),
    .held  (held),
    .dout  (held_byte)
  );

  mdsc_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .din  (held_byte),
    .res  (res_comb)
  );

  mdsc_out_reg u_out_reg (
    .clk   (clk),
    .rst   (rst),
    .load  (res_load),
    .din   (res_comb),
    .stall (result_stall),
    .valid (result_valid),
    .dout  (res_held)
  );

  assign status    = res_held.status;
  assign arg_slots = res_held.arg_slots;

  `MDSC_ASSERT_IMPL(a_stall_only_on_last, item_stall,
    held && held_byte.is_last && result_valid)
  `MDSC_ASSERT_IMPL(a_syntax_zero, result_valid && res_held.status == ST_SYNTAX,
    res_held.arg_slots == '0)
  `MDSC_ASSERT_IMPL(a_overflow_max, result_valid && res_held.status == ST_OVERFLOW,
    res_held.arg_slots == OUT_MAX)
  `MDSC_ASSERT_NEXT(a_result_follows_last, res_load, result_valid)

endmodule
